// ----- rtl/core/wps_pkg.sv -----
// shared types and constants for the ws2812 pixel serializer
// no dependencies; imported by every module of the block
`default_nettype none

package wps_pkg;

   localparam int unsigned BITS_PER_PIXEL = 24;
   localparam logic [23:0] PIXEL_RESET    = 24'h0f0000;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_SLOT_TICKS      = 2'd0,
      REG_HIGH_TICKS_ONE  = 2'd1,
      REG_HIGH_TICKS_ZERO = 2'd2,
      REG_LATCH_SLOTS     = 2'd3
   } reg_index_type;

   localparam logic [7:0] SLOT_TICKS_RESET      = 8'd10;
   localparam logic [7:0] HIGH_TICKS_ONE_RESET  = 8'd7;
   localparam logic [7:0] HIGH_TICKS_ZERO_RESET = 8'd3;
   localparam logic [9:0] LATCH_SLOTS_RESET     = 10'd60;

   typedef struct packed {
      logic [7:0] slot_ticks;
      logic [7:0] high_ticks_one;
      logic [7:0] high_ticks_zero;
      logic [9:0] latch_slots;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/wps_csr.sv -----
// configuration registers behind the apb-style port
// depends on wps_pkg for the register map and the cfg_type struct
`default_nettype none

module wps_csr
   import wps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SLOT_TICKS:      cfg_in.slot_ticks      = csr_pwdata[7:0];
            REG_HIGH_TICKS_ONE:  cfg_in.high_ticks_one  = csr_pwdata[7:0];
            REG_HIGH_TICKS_ZERO: cfg_in.high_ticks_zero = csr_pwdata[7:0];
            REG_LATCH_SLOTS:     cfg_in.latch_slots     = csr_pwdata[9:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SLOT_TICKS:      csr_prdata = {24'd0, cfg_ff.slot_ticks};
         REG_HIGH_TICKS_ONE:  csr_prdata = {24'd0, cfg_ff.high_ticks_one};
         REG_HIGH_TICKS_ZERO: csr_prdata = {24'd0, cfg_ff.high_ticks_zero};
         REG_LATCH_SLOTS:     csr_prdata = {22'd0, cfg_ff.latch_slots};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_ticks      <= SLOT_TICKS_RESET;
         cfg_ff.high_ticks_one  <= HIGH_TICKS_ONE_RESET;
         cfg_ff.high_ticks_zero <= HIGH_TICKS_ZERO_RESET;
         cfg_ff.latch_slots     <= LATCH_SLOTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/wps_store.sv -----
// pixel color memory, one write port and one registered read port
// per-entry valid bits give the reset color; depends on wps_pkg
`default_nettype none

module wps_store
   import wps_pkg::*;
#(
   parameter int unsigned PIXELS = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [23:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [23:0]            rd_data
);

   logic [23:0]       mem [PIXELS];
   logic [PIXELS-1:0] valid_ff;
   logic [23:0]       rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // write-through so the read register always mirrors the addressed entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_data_ff <= PIXEL_RESET;
      end else if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem[rd_addr];
      end else begin
         rd_data_ff <= PIXEL_RESET;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/wps_seq.sv -----
// frame sequencer: slot and tick counters, line level and command decode
// drives the pixel store ports; depends on wps_pkg
`default_nettype none

module wps_seq
   import wps_pkg::*;
#(
   parameter int unsigned PIXELS = 64,
   parameter int unsigned ADDR_W = 6,
   parameter int unsigned PIX_W  = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        cmd,
   input  wire logic [9:0]        pixel_index,
   input  wire logic [7:0]        red,
   input  wire logic [7:0]        green,
   input  wire logic [7:0]        blue,
   input  wire cfg_type           cfg,
   input  wire logic [23:0]       pixel,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [23:0]            wr_data,
   output logic [ADDR_W-1:0]      rd_addr,
   output rsp_type                result
);

   localparam logic [15:0]      DATA_SLOTS = 16'(PIXELS * BITS_PER_PIXEL);
   localparam logic [PIX_W-1:0] PIX_LAST   = PIX_W'(PIXELS);
   localparam logic [10:0]      IDX_LIMIT  = 11'(PIXELS);

   cmd_type          cmd_dec;
   logic             sending_ff, sending_in;
   logic [14:0]      slot_ff, slot_in;
   logic [7:0]       tick_ff, tick_in;
   logic [4:0]       pos_ff, pos_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             line_ff, line_in;
   logic             in_data;
   logic             bit_val;
   logic [7:0]       hi_ticks;
   logic             level;
   logic [14:0]      slot_next;
   logic             slot_end;
   logic             frame_end;
   logic [15:0]      total_slots;

   assign cmd_dec     = cmd_type'(cmd);
   assign in_data     = pix_ff < PIX_LAST;
   assign bit_val     = pixel[5'd23 - pos_ff];
   assign hi_ticks    = bit_val ? cfg.high_ticks_one : cfg.high_ticks_zero;
   assign level       = in_data && (tick_ff < hi_ticks);
   assign slot_next   = slot_ff + 15'd1;
   assign slot_end    = ({1'b0, tick_ff} + 9'd1) >= {1'b0, cfg.slot_ticks};
   assign total_slots = DATA_SLOTS + {6'd0, cfg.latch_slots};
   assign frame_end   = slot_end && ({1'b0, slot_next} >= total_slots);

   assign wr_en   = accept && (cmd_dec == CMD_WRITE) && ({1'b0, pixel_index} < IDX_LIMIT);
   assign wr_addr = pixel_index[ADDR_W-1:0];
   assign wr_data = {green, red, blue};
   assign rd_addr = pix_in[ADDR_W-1:0];

   always_comb begin
      sending_in        = sending_ff;
      slot_in           = slot_ff;
      tick_in           = tick_ff;
      pos_in            = pos_ff;
      pix_in            = pix_ff;
      line_in           = line_ff;
      result.line_level = sending_ff && line_ff;
      result.frame_done = 1'b0;
      if (accept) begin
         case (cmd_dec)
            CMD_START: begin
               if (!sending_ff) begin
                  sending_in = 1'b1;
                  slot_in    = '0;
                  tick_in    = '0;
                  pos_in     = '0;
                  pix_in     = '0;
                  line_in    = 1'b0;
               end
            end
            CMD_TICK: begin
               if (sending_ff) begin
                  result.line_level = level;
                  line_in           = level;
                  if (frame_end) begin
                     sending_in        = 1'b0;
                     slot_in           = '0;
                     tick_in           = '0;
                     pos_in            = '0;
                     pix_in            = '0;
                     line_in           = 1'b0;
                     result.frame_done = 1'b1;
                  end else if (slot_end) begin
                     tick_in = '0;
                     slot_in = slot_next;
                     if (pos_ff == 5'(BITS_PER_PIXEL - 1)) begin
                        pos_in = '0;
                        if (in_data) begin
                           pix_in = pix_ff + PIX_W'(1);
                        end
                     end else begin
                        pos_in = pos_ff + 5'd1;
                     end
                  end else begin
                     tick_in = tick_ff + 8'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      result.busy_res = sending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         slot_ff    <= '0;
         tick_ff    <= '0;
         pos_ff     <= '0;
         pix_ff     <= '0;
         line_ff    <= 1'b0;
      end else begin
         sending_ff <= sending_in;
         slot_ff    <= slot_in;
         tick_ff    <= tick_in;
         pos_ff     <= pos_in;
         pix_ff     <= pix_in;
         line_ff    <= line_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/wps_outq.sv -----
// two-entry result buffer: output register plus skid register
// depends on wps_pkg for rsp_type
`default_nettype none

module wps_outq
   import wps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    head_load;

   assign head_load = !head_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (head_load) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/ws2812_pixel_serializer.sv -----
// top level of the ws2812 pixel serializer
// depends on wps_pkg, wps_csr, wps_store, wps_seq and wps_outq
`default_nettype none

// For every transaction (pixel write, frame start or timer tick) the
// sequencer state and the registered read of the pixel store feed a short
// decode that writes the result into a two-entry output buffer, so a new
// transaction is taken each cycle while req_stall is low, and up to two
// results may wait on a stalled output. req_stall rises only when both
// result entries are full. The store read register follows the pixel of
// the slot being sent, with writes to that pixel forwarded, so a tick sees
// the current color at once. Per-entry valid bits supply the reset color;
// there is no clearing pass. Configuration writes are registered by the port.
module ws2812_pixel_serializer
   import wps_pkg::*;
#(
   parameter int unsigned PIXELS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [9:0]  req_pixel_index,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_line_level,
   output logic             rsp_busy_res,
   output logic             rsp_frame_done,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned PIX_W  = $clog2(PIXELS + 1);

   cfg_type           cfg;
   rsp_type           result;
   rsp_type           rsp_data;
   logic              accept;
   logic              full;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [23:0]       wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [23:0]       pixel;

   assign accept    = req_valid && !full;
   assign req_stall = full;

   assign rsp_line_level = rsp_data.line_level;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_frame_done = rsp_data.frame_done;

   wps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wps_store #(
      .PIXELS (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (pixel)
   );

   wps_seq #(
      .PIXELS (PIXELS),
      .ADDR_W (ADDR_W),
      .PIX_W  (PIX_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .pixel_index (req_pixel_index),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .cfg         (cfg),
      .pixel       (pixel),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .result      (result)
   );

   wps_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a frame end result always reports the block as idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res)
      else $error("frame done reported while busy");

   // an idle result outside the frame end never shows a high line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res && !rsp_frame_done |-> !rsp_line_level)
      else $error("line high while idle");

   // the buffer only fills up behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

`default_nettype wire

// ----- sim/tb_ws2812_pixel_serializer.sv -----
`timescale 1ns / 100ps
// testbench for ws2812_pixel_serializer: a directed table, then random phases under
// several register settings and handshake idling, every transaction checked in order
// depends on wps_pkg and the rtl of the block
module tb_ws2812_pixel_serializer;
   import wps_pkg::*;

   localparam int unsigned PIXELS      = 64;
   localparam int unsigned DATA_SLOTS  = PIXELS * BITS_PER_PIXEL;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct {
      cmd_type    cmd;
      logic [9:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       chk;
      rsp_type    want;
   } dir_row_type;

   typedef struct {
      int slot;
      int one;
      int zero;
      int latch;
      int count;
      int tick_pct;
   } phase_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd         = CMD_NONE;
   logic [9:0]  req_pixel_index = '0;
   logic [7:0]  req_red         = '0;
   logic [7:0]  req_green       = '0;
   logic [7:0]  req_blue        = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b1;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic        rsp_frame_done;
   logic        csr_psel        = 1'b0;
   logic        csr_penable     = 1'b0;
   logic        csr_pwrite      = 1'b0;
   logic [3:0]  csr_paddr       = '0;
   logic [31:0] csr_pwdata      = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // checker state
   logic        row_chk  = 1'b0;
   rsp_type     row_want = '0;
   rsp_type     pending_rsp[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   // behavioral copy of the serializer
   logic [23:0] pix_mem[PIXELS];
   logic        frame_on = 1'b0;
   logic [14:0] slot_cnt = '0;
   logic [7:0]  tick_cnt = '0;
   logic        line_reg = 1'b0;
   cfg_type     cfg = '{SLOT_TICKS_RESET, HIGH_TICKS_ONE_RESET,
                        HIGH_TICKS_ZERO_RESET, LATCH_SLOTS_RESET};

   dir_row_type dir_rows[18] = '{
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
      '{CMD_NONE,  10'h3ff, 8'hff, 8'hff, 8'hff, 1'b1, 3'b000},
      '{CMD_WRITE, 10'd0,   8'h00, 8'hff, 8'h00, 1'b1, 3'b000},
      '{CMD_WRITE, 10'd63,  8'hff, 8'h00, 8'hff, 1'b1, 3'b000},
      '{CMD_WRITE, 10'd64,  8'haa, 8'h55, 8'haa, 1'b1, 3'b000},
      '{CMD_WRITE, 10'h3ff, 8'hff, 8'hff, 8'hff, 1'b1, 3'b000},
      '{CMD_START, 10'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b010},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
      '{CMD_START, 10'd5,   8'h12, 8'h34, 8'h56, 1'b1, 3'b110},
      '{CMD_WRITE, 10'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
      '{CMD_NONE,  10'd1,   8'h01, 8'h01, 8'h01, 1'b0, 3'b000},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
      '{CMD_WRITE, 10'd1,   8'h80, 8'h80, 8'h80, 1'b0, 3'b000},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
      '{CMD_TICK,  10'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000}
   };

   // slot, one, zero, latch, transactions, tick percent
   phase_type phases[6] = '{
      '{10,  7,   3,   60,   150, 60},
      '{1,   1,   0,   0,    300, 93},
      '{255, 255, 0,   1023, 150, 70},
      '{0,   0,   1,   1023, 300, 94},
      '{3,   2,   1,   5,    250, 60},
      '{2,   0,   255, 1,    80,  80}
   };

   ws2812_pixel_serializer #(
      .PIXELS(PIXELS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_level  (rsp_line_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_frame_done  (rsp_frame_done),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type advance_serializer(cmd_type c, logic [9:0] idx,
                                                  logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
      rsp_type     res;
      int unsigned total;
      logic        bit_val;
      logic [7:0]  high_len;
      res   = '0;
      total = DATA_SLOTS + cfg.latch_slots;
      case (c)
         CMD_WRITE: begin
            if (idx < PIXELS)
               pix_mem[idx] = {g, r, b};
            res.line_level = frame_on & line_reg;
         end
         CMD_START: begin
            if (!frame_on) begin
               frame_on = 1'b1;
               slot_cnt = '0;
               tick_cnt = '0;
               line_reg = 1'b0;
            end
            res.line_level = line_reg;
         end
         CMD_TICK: begin
            if (frame_on) begin
               if (slot_cnt < DATA_SLOTS) begin
                  bit_val  = pix_mem[slot_cnt / BITS_PER_PIXEL][23 - slot_cnt % BITS_PER_PIXEL];
                  high_len = bit_val ? cfg.high_ticks_one : cfg.high_ticks_zero;
                  line_reg = (tick_cnt < high_len);
               end else begin
                  line_reg = 1'b0;
               end
               res.line_level = line_reg;
               if (int'(tick_cnt) + 1 >= int'(cfg.slot_ticks)) begin
                  tick_cnt = '0;
                  slot_cnt = slot_cnt + 1'b1;
                  if (slot_cnt >= total) begin
                     frame_on       = 1'b0;
                     slot_cnt       = '0;
                     line_reg       = 1'b0;
                     res.frame_done = 1'b1;
                  end
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
               end
            end
         end
         default: begin
            res.line_level = frame_on & line_reg;
         end
      endcase
      res.busy_res = frame_on;
      return res;
   endfunction

   task automatic report_mismatch(string field, int want, int got);
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, field, want, got);
      error_count++;
   endtask

   // transaction tracking and result check
   always @(posedge clock) begin
      rsp_type pred;
      rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ws2812_pixel_serializer failed");
            $finish;
         end else begin
            if (req_valid && !req_stall) begin
               pred = advance_serializer(cmd_type'(req_cmd), req_pixel_index,
                                         req_red, req_green, req_blue);
               pending_rsp.push_back(row_chk ? row_want : pred);
            end
            if (rsp_valid && !rsp_stall) begin
               if (pending_rsp.size() == 0) begin
                  report_mismatch("unexpected transaction", 0, 1);
               end else begin
                  want = pending_rsp.pop_front();
                  if (rsp_line_level !== want.line_level)
                     report_mismatch("line_level", want.line_level, rsp_line_level);
                  if (rsp_busy_res !== want.busy_res)
                     report_mismatch("busy_res", want.busy_res, rsp_busy_res);
                  if (rsp_frame_done !== want.frame_done)
                     report_mismatch("frame_done", want.frame_done, rsp_frame_done);
               end
            end
         end
      end
   end

   // receiver side stall, with a long hold on request
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(cmd_type c, logic [9:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic chk, rsp_type want);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c;
      req_pixel_index <= idx;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      row_chk         <= chk;
      row_want        <= want;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random(int tick_pct);
      cmd_type    c;
      int         roll;
      int         span;
      logic [9:0] idx;
      roll = $urandom_range(0, 99);
      span = 100 - tick_pct;
      if (roll < tick_pct)
         c = CMD_TICK;
      else if ((roll - tick_pct) * 10 < span * 5)
         c = CMD_WRITE;
      else if ((roll - tick_pct) * 10 < span * 9)
         c = CMD_START;
      else
         c = CMD_NONE;
      if ($urandom_range(0, 9) == 0)
         idx = $urandom_range(0, 1023);
      else
         idx = $urandom_range(0, PIXELS - 1);
      send_item(c, idx, $urandom, $urandom, $urandom, 1'b0, '0);
   endtask

   // write all four registers; meant for use only while the block is idle, which this task does not check
   task automatic load_config(phase_type ph);
      logic [31:0] vals[4];
      vals = '{ph.slot, ph.one, ph.zero, ph.latch};
      for (int i = 0; i < 4; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {reg_index_type'(i), 2'b00};
         csr_pwdata  <= vals[i];
         @(negedge clock);
         csr_penable <= 1'b1;
         do
            @(posedge clock);
         while (!csr_pready);
         @(negedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg.slot_ticks      = vals[REG_SLOT_TICKS][7:0];
      cfg.high_ticks_one  = vals[REG_HIGH_TICKS_ONE][7:0];
      cfg.high_ticks_zero = vals[REG_HIGH_TICKS_ZERO][7:0];
      cfg.latch_slots     = vals[REG_LATCH_SLOTS][9:0];
   endtask

   initial begin
      int mode;
      foreach (pix_mem[i])
         pix_mem[i] = PIXEL_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].red, dir_rows[i].green,
                   dir_rows[i].blue, dir_rows[i].chk, dir_rows[i].want);

      foreach (phases[p]) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0)
               @(negedge clock);
            repeat (4) @(negedge clock);
            load_config(phases[p]);
            @(negedge clock);
         end
         // no idling, sender idle, receiver stall, both
         mode         = p % 4;
         tx_idle_pct  = (mode == 1) ? 62 : (mode == 3) ? 7 : 0;
         rx_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 7 : 0;
         for (int n = 0; n < phases[p].count; n++) begin
            if (p == 4 && n == 40)
               hold_asked++;
            if (p == 4 && n == 150) begin
               req_valid <= 1'b0;
               while (pending_rsp.size() != 0)
                  @(negedge clock);
               @(negedge clock);
            end
            send_random(phases[p].tick_pct);
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb_ws2812_pixel_serializer passed");
      else
         $display("tb_ws2812_pixel_serializer failed");
      $finish;
   end

endmodule
